// File: hdl/fbs_pkg.sv
// shared types and constants for the fennel block selector
`default_nettype none
package fbs_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int BLK_W      = 7;
  localparam int W_W        = 32;
  localparam int NW_W       = 16;
  localparam int A_W        = 48;
  localparam int PF_W       = 49;
  localparam int SC_W       = 51;
  localparam int MW_W       = 34;
  localparam int CFG_IDX_W  = 2;

  localparam logic [BLK_W-1:0] NO_BLOCK = BLK_W'(64);
  localparam logic [BLK_W-1:0] K_MIN    = BLK_W'(2);
  localparam logic [BLK_W-1:0] K_MAX    = BLK_W'(MAX_BLOCKS);

  localparam logic [2:0] OP_BEGIN  = 3'd0;
  localparam logic [2:0] OP_EDGE   = 3'd1;
  localparam logic [2:0] OP_DECIDE = 3'd2;
  localparam logic [2:0] OP_MINW   = 3'd3;
  localparam logic [2:0] OP_PLACE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAMMA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PART_WEIGHT = 2'd2;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_BEGIN,
    CMD_DISPATCH,
    CMD_EDGE_RD,
    CMD_EDGE_WR,
    CMD_DEC_INIT,
    CMD_RD_IDX,
    CMD_EV_START,
    CMD_MUL_LO,
    CMD_MUL_HI,
    CMD_EV_PEN,
    CMD_EV_CMP,
    CMD_MIN_CMP,
    CMD_MV_SETUP,
    CMD_FROM_RD,
    CMD_FROM_WR,
    CMD_TO_RD,
    CMD_TO_WR,
    CMD_OUT
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_EDGE_RD,
    S_EDGE_WR,
    S_DEC_INIT,
    S_EV_RD,
    S_EV_START,
    S_EV_WAIT,
    S_EV_MLO,
    S_EV_MHI,
    S_EV_PEN,
    S_EV_CMP,
    S_MIN_RD,
    S_MIN_CMP,
    S_MV_SETUP,
    S_FROM_RD,
    S_FROM_WR,
    S_TO_RD,
    S_TO_WR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] op;
    logic       edge_skip;
    logic       scan_last;
    logic       min_last;
    logic       mv_go;
    logic       from_ok;
    logic       sqrt_done;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/fennel_block_selector.sv
// top level of the fennel block selector, one item at a time
// items are begin, edge, place, min-weight assign and decide; decide scores every block in turn
// and waits on the bit-serial square root for each block that it scores
// a result waiting on a stalled full output register holds the input until it drains
// the result sits in an output register, so a new item is taken while it waits
// synchronous active-low reset clears all weights and scores at once through valid flags
`default_nettype none
module fennel_block_selector
  import fbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           in_op,
  input  wire logic [NW_W-1:0]      in_node_weight,
  input  wire logic [BLK_W-1:0]     in_node_block,
  input  wire logic [NW_W-1:0]      in_edge_wt,
  input  wire logic [IDX_W-1:0]     in_target_block,
  input  wire logic                 in_only_pin_in_block,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BLK_W-1:0]          out_chosen_block,
  output logic signed [W_W-1:0]     out_top_score,
  output logic                      out_moved,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [W_W-1:0]       cfg_wdata
);

  cmd_t       cmd;
  dp_status_t status;

  fbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fbs_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_op                (in_op),
    .in_node_weight       (in_node_weight),
    .in_node_block        (in_node_block),
    .in_edge_wt           (in_edge_wt),
    .in_target_block      (in_target_block),
    .in_only_pin_in_block (in_only_pin_in_block),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_chosen_block     (out_chosen_block),
    .out_top_score        (out_top_score),
    .out_moved            (out_moved),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

endmodule
`default_nettype wire

// File: hdl/fbs_sqrt.sv
// iterative square root of an integer block weight, root in q16.16, one root bit per cycle
`default_nettype none
module fbs_sqrt
  import fbs_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W_W-1:0] rad,
  output logic                done,
  output logic [W_W-1:0]      root
);

  logic [2*W_W-1:0] x_r;
  logic [W_W+2:0]   rem_r;
  logic [W_W-1:0]   root_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [W_W+2:0] rem_sh;
  logic [W_W+2:0] trial;

  assign rem_sh = {rem_r[W_W:0], x_r[2*W_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'(W_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= {rad, {W_W{1'b0}}};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r <= {x_r[2*W_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[W_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[W_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// File: hdl/fbs_datapath.sv
// datapath: config registers, block weight and score memories, penalty arithmetic, result register
`default_nettype none
module fbs_datapath
  import fbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output dp_status_t                status,
  input  wire logic [2:0]           in_op,
  input  wire logic [NW_W-1:0]      in_node_weight,
  input  wire logic [BLK_W-1:0]     in_node_block,
  input  wire logic [NW_W-1:0]      in_edge_wt,
  input  wire logic [IDX_W-1:0]     in_target_block,
  input  wire logic                 in_only_pin_in_block,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BLK_W-1:0]          out_chosen_block,
  output logic signed [W_W-1:0]     out_top_score,
  output logic                      out_moved,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [W_W-1:0]       cfg_wdata
);

  // config
  logic [BLK_W-1:0] bc_r;
  logic [W_W-1:0]   ag_r;
  logic [W_W-1:0]   mpw_r;
  logic [BLK_W-1:0] k_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r  <= K_MIN;
      ag_r  <= W_W'(65536);
      mpw_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_COUNT:     bc_r  <= cfg_wdata[BLK_W-1:0];
        CFG_ALPHA_GAMMA:     ag_r  <= cfg_wdata;
        CFG_MAX_PART_WEIGHT: mpw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    k_c = bc_r;
    if (bc_r < K_MIN) k_c = K_MIN;
    else if (bc_r > K_MAX) k_c = K_MAX;
  end

  // item and current node
  logic [2:0]       op_r;
  logic [NW_W-1:0]  nw_r;
  logic [BLK_W-1:0] nb_r;
  logic [NW_W-1:0]  ew_r;
  logic [IDX_W-1:0] tb_r;
  logic             only_r;
  logic [NW_W-1:0]  cur_nw_r;
  logic [BLK_W-1:0] cur_nb_r;

  logic [BLK_W-1:0] tb_ext;
  logic             cur_assigned;
  logic [BLK_W-1:0] dec_from;

  assign tb_ext       = {1'b0, tb_r};
  assign cur_assigned = cur_nb_r < k_c;
  assign dec_from     = cur_assigned ? cur_nb_r : NO_BLOCK;

  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      op_r   <= in_op;
      nw_r   <= in_node_weight;
      nb_r   <= (in_node_block >= k_c) ? NO_BLOCK : in_node_block;
      ew_r   <= in_edge_wt;
      tb_r   <= in_target_block;
      only_r <= in_only_pin_in_block;
    end
  end

  // memories
  logic [W_W-1:0]        wmem [MAX_BLOCKS];
  logic [W_W-1:0]        smem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] wv_r;
  logic [MAX_BLOCKS-1:0] sv_r;
  logic [W_W-1:0]        w_rd_r;
  logic [W_W-1:0]        s_rd_r;
  logic                  w_rv_r;
  logic                  s_rv_r;

  logic [BLK_W-1:0] idx_r;
  logic [BLK_W-1:0] mv_from_r;
  logic [BLK_W-1:0] mv_to_r;
  logic [NW_W-1:0]  mv_nw_r;

  logic [IDX_W-1:0]    w_raddr;
  logic [IDX_W-1:0]    s_raddr;
  logic                w_we;
  logic [IDX_W-1:0]    w_waddr;
  logic [W_W-1:0]      w_wdata;
  logic                s_we;
  logic [W_W-1:0]      s_wdata;
  logic [W_W-1:0]      wq;
  logic signed [W_W-1:0] sq;
  logic [W_W:0]        wsum;
  logic signed [W_W:0] esum;

  always_comb begin
    case (cmd)
      CMD_FROM_RD: w_raddr = mv_from_r[IDX_W-1:0];
      CMD_TO_RD:   w_raddr = mv_to_r[IDX_W-1:0];
      default:     w_raddr = idx_r[IDX_W-1:0];
    endcase
  end

  assign s_raddr = (cmd == CMD_EDGE_RD) ? tb_r : idx_r[IDX_W-1:0];
  assign wq      = w_rv_r ? w_rd_r : '0;
  assign sq      = s_rv_r ? $signed(s_rd_r) : '0;

  assign w_we    = (cmd == CMD_FROM_WR) || (cmd == CMD_TO_WR);
  assign w_waddr = (cmd == CMD_FROM_WR) ? mv_from_r[IDX_W-1:0] : mv_to_r[IDX_W-1:0];
  assign wsum    = {1'b0, wq} + (W_W+1)'(mv_nw_r);

  always_comb begin
    if (cmd == CMD_FROM_WR) begin
      w_wdata = (wq >= W_W'(mv_nw_r)) ? wq - W_W'(mv_nw_r) : '0;
    end else begin
      w_wdata = wsum[W_W] ? '1 : wsum[W_W-1:0];
    end
  end

  assign s_we    = (cmd == CMD_EDGE_WR);
  assign esum    = {sq[W_W-1], sq} + $signed({1'b0, W_W'(ew_r)});
  assign s_wdata = (esum > $signed({2'b00, {(W_W-1){1'b1}}})) ? {1'b0, {(W_W-1){1'b1}}}
                                                             : esum[W_W-1:0];

  always_ff @(posedge clk) begin
    w_rd_r <= wmem[w_raddr];
    s_rd_r <= smem[s_raddr];
    if (w_we) wmem[w_waddr] <= w_wdata;
    if (s_we) smem[tb_r] <= s_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r   <= '0;
      sv_r   <= '0;
      w_rv_r <= 1'b0;
      s_rv_r <= 1'b0;
    end else begin
      w_rv_r <= wv_r[w_raddr];
      s_rv_r <= sv_r[s_raddr];
      if (w_we) wv_r[w_waddr] <= 1'b1;
      if (cmd == CMD_BEGIN || (cmd == CMD_MV_SETUP && op_r == OP_DECIDE)) begin
        sv_r <= '0;
      end else if (s_we) begin
        sv_r[tb_r] <= 1'b1;
      end
    end
  end

  // penalty arithmetic
  logic [A_W-1:0]          a_r;
  logic                    first_r;
  logic                    fit_r;
  logic signed [W_W-1:0]   sc_hold_r;
  logic [2*W_W-1:0]        lo_r;
  logic [A_W-1:0]          hi_r;
  logic signed [SC_W-1:0]  sc_r;
  logic [BLK_W-1:0]        best_r;
  logic signed [SC_W-1:0]  best_sc_r;
  logic signed [MW_W-1:0]  minw_r;

  logic [W_W-1:0]          w_eval;
  logic                    sq_done;
  logic [W_W-1:0]          sq_root;
  logic [W_W-1:0]          mul_x;
  logic [2*W_W-1:0]        mul_p;
  logic [PF_W-1:0]         pf;
  logic [PF_W-1:0]         pc;
  logic signed [SC_W-1:0]  sc_ext;
  logic signed [SC_W-1:0]  pf_s;
  logic signed [SC_W-1:0]  pc_s;
  logic [BLK_W-1:0]        cand0;
  logic [BLK_W-1:0]        cand;
  logic signed [MW_W-1:0]  eff_w;
  logic                    ev_upd;

  always_comb begin
    if (first_r) begin
      w_eval = (wq >= W_W'(cur_nw_r)) ? wq - W_W'(cur_nw_r) : '0;
    end else begin
      w_eval = wq;
    end
  end

  fbs_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd == CMD_EV_START),
    .rad   (w_eval),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign mul_x  = (cmd == CMD_MUL_HI) ? W_W'(a_r[A_W-1:W_W]) : a_r[W_W-1:0];
  assign mul_p  = mul_x * sq_root;
  assign pf     = PF_W'(hi_r) + PF_W'(lo_r[2*W_W-1:W_W]);
  assign pc     = pf + PF_W'(|lo_r[W_W-1:0]);
  assign sc_ext = SC_W'(sc_hold_r);
  assign pf_s   = $signed({2'b00, pf});
  assign pc_s   = $signed({2'b00, pc});
  assign cand0  = first_r ? '0 : idx_r + BLK_W'(1);
  assign cand   = (cand0 == dec_from) ? cand0 + BLK_W'(1) : cand0;
  assign ev_upd = first_r || (fit_r && (sc_r > best_sc_r));
  assign eff_w  = $signed({2'b00, wq}) -
                  ((idx_r == nb_r) ? $signed(MW_W'(nw_r)) : $signed(MW_W'(0)));

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_DISPATCH: begin
        idx_r   <= '0;
        first_r <= 1'b1;
      end
      CMD_DEC_INIT: begin
        a_r       <= cur_nw_r * ag_r;
        best_r    <= dec_from;
        best_sc_r <= -SC_W'(signed'(64'sd2147483647));
        idx_r     <= cur_assigned ? cur_nb_r : '0;
        first_r   <= cur_assigned;
      end
      CMD_EV_START: begin
        fit_r     <= ({1'b0, wq} + (W_W+1)'(cur_nw_r)) <= {1'b0, mpw_r};
        sc_hold_r <= sq;
      end
      CMD_MUL_LO: lo_r <= mul_p;
      CMD_MUL_HI: hi_r <= mul_p[A_W-1:0];
      CMD_EV_PEN: sc_r <= (sc_ext >= pc_s) ? sc_ext - pc_s : sc_ext - pf_s;
      CMD_EV_CMP: begin
        if (ev_upd) begin
          best_r    <= idx_r;
          best_sc_r <= sc_r;
        end
        idx_r   <= cand;
        first_r <= 1'b0;
      end
      CMD_MIN_CMP: begin
        if (first_r || (eff_w < minw_r)) begin
          minw_r <= eff_w;
          best_r <= idx_r;
        end
        idx_r   <= idx_r + BLK_W'(1);
        first_r <= 1'b0;
      end
      default: ;
    endcase
  end

  // move setup and result
  logic [BLK_W-1:0]      mv_from_c;
  logic [BLK_W-1:0]      mv_to_c;
  logic [NW_W-1:0]       mv_nw_c;
  logic                  mv_go_c;
  logic [BLK_W-1:0]      chosen_c;
  logic signed [W_W-1:0] score_c;
  logic signed [W_W-1:0] best_sat;
  logic [BLK_W-1:0]      chosen_r;
  logic signed [W_W-1:0] score_r;
  logic                  moved_r;
  logic                  out_valid_r;
  logic                  out_free;

  always_comb begin
    if (best_sc_r > SC_W'(signed'(64'sd2147483647))) begin
      best_sat = {1'b0, {(W_W-1){1'b1}}};
    end else if (best_sc_r < -SC_W'(signed'(64'sd2147483648))) begin
      best_sat = {1'b1, {(W_W-1){1'b0}}};
    end else begin
      best_sat = best_sc_r[W_W-1:0];
    end
  end

  always_comb begin
    case (op_r)
      OP_DECIDE: begin
        mv_from_c = dec_from;
        mv_to_c   = best_r;
        mv_nw_c   = cur_nw_r;
        mv_go_c   = (best_r != NO_BLOCK) && (best_r != dec_from);
        chosen_c  = best_r;
        score_c   = best_sat;
      end
      OP_MINW: begin
        mv_from_c = nb_r;
        mv_to_c   = best_r;
        mv_nw_c   = nw_r;
        mv_go_c   = best_r != nb_r;
        chosen_c  = best_r;
        score_c   = '0;
      end
      default: begin
        mv_from_c = nb_r;
        mv_to_c   = tb_ext;
        mv_nw_c   = nw_r;
        mv_go_c   = (tb_ext < k_c) && (tb_ext != nb_r);
        chosen_c  = (tb_ext < k_c) ? tb_ext : NO_BLOCK;
        score_c   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_MV_SETUP) begin
      mv_from_r <= mv_from_c;
      mv_to_r   <= mv_to_c;
      mv_nw_r   <= mv_nw_c;
      chosen_r  <= chosen_c;
      score_r   <= score_c;
      moved_r   <= mv_go_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_nw_r <= '0;
      cur_nb_r <= NO_BLOCK;
    end else if (cmd == CMD_BEGIN) begin
      cur_nw_r <= nw_r;
      cur_nb_r <= nb_r;
    end else if (cmd == CMD_MV_SETUP && op_r == OP_DECIDE && mv_go_c) begin
      cur_nb_r <= best_r;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_OUT) begin
      out_chosen_block <= chosen_r;
      out_top_score    <= score_r;
      out_moved        <= moved_r;
    end
  end

  assign out_valid = out_valid_r;

  assign status.op        = op_r;
  assign status.edge_skip = (tb_ext >= k_c) || (cur_assigned && (tb_ext == cur_nb_r) && only_r);
  assign status.scan_last = cand >= k_c;
  assign status.min_last  = (idx_r + BLK_W'(1)) >= k_c;
  assign status.mv_go     = mv_go_c;
  assign status.from_ok   = mv_from_c < k_c;
  assign status.sqrt_done = sq_done;
  assign status.out_free  = out_free;

endmodule
`default_nettype wire

// File: hdl/fbs_ctrl.sv
// controller state machine sequencing the datapath per item
`default_nettype none
module fbs_ctrl
  import fbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output cmd_t            cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (status.op)
          OP_EDGE:   state_nxt = status.edge_skip ? S_IDLE : S_EDGE_RD;
          OP_DECIDE: state_nxt = S_DEC_INIT;
          OP_MINW:   state_nxt = S_MIN_RD;
          OP_PLACE:  state_nxt = S_MV_SETUP;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_EDGE_RD:  state_nxt = S_EDGE_WR;
      S_EDGE_WR:  state_nxt = S_IDLE;
      S_DEC_INIT: state_nxt = S_EV_RD;
      S_EV_RD:    state_nxt = S_EV_START;
      S_EV_START: state_nxt = S_EV_WAIT;
      S_EV_WAIT:  if (status.sqrt_done) state_nxt = S_EV_MLO;
      S_EV_MLO:   state_nxt = S_EV_MHI;
      S_EV_MHI:   state_nxt = S_EV_PEN;
      S_EV_PEN:   state_nxt = S_EV_CMP;
      S_EV_CMP:   state_nxt = status.scan_last ? S_MV_SETUP : S_EV_RD;
      S_MIN_RD:   state_nxt = S_MIN_CMP;
      S_MIN_CMP:  state_nxt = status.min_last ? S_MV_SETUP : S_MIN_RD;
      S_MV_SETUP: begin
        if (!status.mv_go)       state_nxt = S_OUT;
        else if (status.from_ok) state_nxt = S_FROM_RD;
        else                     state_nxt = S_TO_RD;
      end
      S_FROM_RD:  state_nxt = S_FROM_WR;
      S_FROM_WR:  state_nxt = S_TO_RD;
      S_TO_RD:    state_nxt = S_TO_WR;
      S_TO_WR:    state_nxt = S_OUT;
      S_OUT:      if (status.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = CMD_NONE;
    unique case (state_r)
      S_IDLE:     if (in_valid) cmd = CMD_LOAD;
      S_DISPATCH: cmd = (status.op == OP_BEGIN) ? CMD_BEGIN : CMD_DISPATCH;
      S_EDGE_RD:  cmd = CMD_EDGE_RD;
      S_EDGE_WR:  cmd = CMD_EDGE_WR;
      S_DEC_INIT: cmd = CMD_DEC_INIT;
      S_EV_RD:    cmd = CMD_RD_IDX;
      S_EV_START: cmd = CMD_EV_START;
      S_EV_MLO:   cmd = CMD_MUL_LO;
      S_EV_MHI:   cmd = CMD_MUL_HI;
      S_EV_PEN:   cmd = CMD_EV_PEN;
      S_EV_CMP:   cmd = CMD_EV_CMP;
      S_MIN_RD:   cmd = CMD_RD_IDX;
      S_MIN_CMP:  cmd = CMD_MIN_CMP;
      S_MV_SETUP: cmd = CMD_MV_SETUP;
      S_FROM_RD:  cmd = CMD_FROM_RD;
      S_FROM_WR:  cmd = CMD_FROM_WR;
      S_TO_RD:    cmd = CMD_TO_RD;
      S_TO_WR:    cmd = CMD_TO_WR;
      S_OUT:      if (status.out_free) cmd = CMD_OUT;
      default:    cmd = CMD_NONE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire
